[src/arr_pkg.sv]
package arr_pkg;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PARENT  = 3'd1,
    ST_ANCHOR  = 3'd2,
    ST_PIVOT   = 3'd3,
    ST_DPI     = 3'd4,
    ST_MARGIN  = 3'd5,
    ST_PADDING = 3'd6,
    ST_OUTRECT = 3'd7
  } status_e;

  // 1.0 for anchor and pivot fractions
  localparam logic [17:0] UnitOne = 18'd65536;
  localparam logic signed [27:0] CoordMin = -28'sd8388608;
  localparam logic signed [27:0] CoordMax = 28'sd8388607;

  // DPI-scaled coordinate, and an edge or size after the sums
  typedef logic signed [24:0] scl_t;
  typedef logic signed [26:0] edge_t;

  typedef struct packed {
    status_e             status;
    logic signed [19:0]  px;
    logic signed [19:0]  py;
    logic [19:0]         a0x;
    logic [19:0]         a0y;
    logic [19:0]         a1x;
    logic [19:0]         a1y;
    scl_t                o0x;
    scl_t                o0y;
    scl_t                o1x;
    scl_t                o1y;
    scl_t                ml;
    scl_t                mb;
    scl_t                mr;
    scl_t                mt;
    scl_t                pl;
    scl_t                pb;
    scl_t                plr;
    scl_t                ptb;
    logic [16:0]         pvx;
    logic [16:0]         pvy;
  } s1_t;

  typedef struct packed {
    status_e     status;
    edge_t       left;
    edge_t       bottom;
    edge_t       right;
    edge_t       top;
    scl_t        pl;
    scl_t        pb;
    scl_t        plr;
    scl_t        ptb;
    logic [16:0] pvx;
    logic [16:0] pvy;
  } s2_t;

  typedef struct packed {
    status_e     status;
    edge_t       left;
    edge_t       bottom;
    edge_t       w;
    edge_t       h;
    edge_t       cl;
    edge_t       cb;
    edge_t       cw;
    edge_t       ch;
    logic [16:0] pvx;
    logic [16:0] pvy;
  } s3_t;

  typedef struct packed {
    status_e     status;
    edge_t       left;
    edge_t       bottom;
    edge_t       w;
    edge_t       h;
    edge_t       cl;
    edge_t       cb;
    edge_t       cw;
    edge_t       ch;
    logic [26:0] pox;
    logic [26:0] poy;
  } s4_t;

  function automatic logic in_unit(input logic [17:0] a);
    return !a[17] && (a <= UnitOne);
  endfunction

  // product with a Q4.12 scale, floor of the shift
  function automatic scl_t scale_mul(input logic signed [20:0] v,
                                     input logic signed [15:0] dpi);
    logic signed [36:0] p;
    p = 37'(v) * 37'(dpi);
    return p[36:12];
  endfunction

  // non-negative length times a fraction in 0..1.0
  function automatic logic [19:0] anchor_mul(input logic [18:0] len,
                                             input logic [16:0] a);
    logic [35:0] p;
    p = 36'(len) * 36'(a);
    return p[35:16];
  endfunction

  function automatic logic [23:0] sat_coord(input logic signed [27:0] v);
    if (v < CoordMin) begin
      return 24'h800000;
    end else if (v > CoordMax) begin
      return 24'h7FFFFF;
    end
    return v[23:0];
  endfunction

  function automatic logic [22:0] sat_size(input logic signed [27:0] v);
    if (v < 28'sd0) begin
      return 23'd0;
    end else if (v > CoordMax) begin
      return 23'h7FFFFF;
    end
    return v[22:0];
  endfunction

endpackage

[src/arr_if.sv]
interface arr_in_if;
  logic                valid;
  logic                ready;
  logic [39:0]         parent_position;
  logic [39:0]         parent_size;
  logic [35:0]         anchor_low;
  logic [35:0]         anchor_high;
  logic [35:0]         pivot_fraction;
  logic [39:0]         offset_low;
  logic [39:0]         offset_high;
  logic [39:0]         margin_horizontal;
  logic [39:0]         margin_vertical;
  logic [39:0]         padding_horizontal;
  logic [39:0]         padding_vertical;
  logic signed [15:0]  scale_factor;

  modport source (
    output valid, parent_position, parent_size, anchor_low, anchor_high,
           pivot_fraction, offset_low, offset_high, margin_horizontal,
           margin_vertical, padding_horizontal, padding_vertical, scale_factor,
    input  ready
  );

  modport sink (
    input  valid, parent_position, parent_size, anchor_low, anchor_high,
           pivot_fraction, offset_low, offset_high, margin_horizontal,
           margin_vertical, padding_horizontal, padding_vertical, scale_factor,
    output ready
  );
endinterface

interface arr_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [23:0] rect_x;
  logic signed [23:0] rect_y;
  logic [22:0]        rect_width;
  logic [22:0]        rect_height;
  logic signed [23:0] content_x;
  logic signed [23:0] content_y;
  logic [22:0]        inner_width;
  logic [22:0]        inner_height;
  logic signed [23:0] pivot_x;
  logic signed [23:0] pivot_y;

  modport source (
    output valid, status, rect_x, rect_y, rect_width, rect_height, content_x,
           content_y, inner_width, inner_height, pivot_x, pivot_y,
    input  ready
  );

  modport sink (
    input  valid, status, rect_x, rect_y, rect_width, rect_height, content_x,
           content_y, inner_width, inner_height, pivot_x, pivot_y,
    output ready
  );
endinterface

[src/arr_front.sv]
module arr_front import arr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  arr_in_if.sink   in_i,
  output logic     valid_o,
  output s1_t      data_o,
  input  logic     ready_i
);

  logic               v_q;
  s1_t                s_d;
  s1_t                s_q;
  logic               adv;

  logic signed [19:0] px, py, pw, ph;
  logic [17:0]        a0x, a0y, a1x, a1y, pvx, pvy;
  logic signed [19:0] o0x, o0y, o1x, o1y;
  logic signed [19:0] ml, mr, mb, mt, pl, pr, pb, pt;
  logic signed [15:0] dpi;
  logic               anchor_bad;

  always_comb begin
    px  = in_i.parent_position[19:0];
    py  = in_i.parent_position[39:20];
    pw  = in_i.parent_size[19:0];
    ph  = in_i.parent_size[39:20];
    a0x = in_i.anchor_low[17:0];
    a0y = in_i.anchor_low[35:18];
    a1x = in_i.anchor_high[17:0];
    a1y = in_i.anchor_high[35:18];
    pvx = in_i.pivot_fraction[17:0];
    pvy = in_i.pivot_fraction[35:18];
    o0x = in_i.offset_low[19:0];
    o0y = in_i.offset_low[39:20];
    o1x = in_i.offset_high[19:0];
    o1y = in_i.offset_high[39:20];
    ml  = in_i.margin_horizontal[19:0];
    mr  = in_i.margin_horizontal[39:20];
    mb  = in_i.margin_vertical[19:0];
    mt  = in_i.margin_vertical[39:20];
    pl  = in_i.padding_horizontal[19:0];
    pr  = in_i.padding_horizontal[39:20];
    pb  = in_i.padding_vertical[19:0];
    pt  = in_i.padding_vertical[39:20];
    dpi = in_i.scale_factor;

    // order compare is only meaningful once all four are in range
    anchor_bad = !in_unit(a0x) || !in_unit(a0y) || !in_unit(a1x) || !in_unit(a1y) ||
                 (a0x > a1x) || (a0y > a1y);

    if (pw[19] || ph[19]) begin
      s_d.status = ST_PARENT;
    end else if (anchor_bad) begin
      s_d.status = ST_ANCHOR;
    end else if (!in_unit(pvx) || !in_unit(pvy)) begin
      s_d.status = ST_PIVOT;
    end else if (dpi[15] || (dpi == 16'sd0)) begin
      s_d.status = ST_DPI;
    end else if (ml[19] || mr[19] || mb[19] || mt[19]) begin
      s_d.status = ST_MARGIN;
    end else if (pl[19] || pr[19] || pb[19] || pt[19]) begin
      s_d.status = ST_PADDING;
    end else begin
      s_d.status = ST_OK;
    end

    s_d.px  = px;
    s_d.py  = py;
    s_d.a0x = anchor_mul(pw[18:0], a0x[16:0]);
    s_d.a0y = anchor_mul(ph[18:0], a0y[16:0]);
    s_d.a1x = anchor_mul(pw[18:0], a1x[16:0]);
    s_d.a1y = anchor_mul(ph[18:0], a1y[16:0]);
    s_d.o0x = scale_mul(21'(o0x), dpi);
    s_d.o0y = scale_mul(21'(o0y), dpi);
    s_d.o1x = scale_mul(21'(o1x), dpi);
    s_d.o1y = scale_mul(21'(o1y), dpi);
    s_d.ml  = scale_mul(21'(ml), dpi);
    s_d.mb  = scale_mul(21'(mb), dpi);
    s_d.mr  = scale_mul(21'(mr), dpi);
    s_d.mt  = scale_mul(21'(mt), dpi);
    s_d.pl  = scale_mul(21'(pl), dpi);
    s_d.pb  = scale_mul(21'(pb), dpi);
    s_d.plr = scale_mul(21'(pl) + 21'(pr), dpi);
    s_d.ptb = scale_mul(21'(pt) + 21'(pb), dpi);
    s_d.pvx = pvx[16:0];
    s_d.pvy = pvy[16:0];
  end

  assign adv        = !v_q || ready_i;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_i.valid) begin
      s_q <= s_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = s_q;

endmodule

[src/arr_edge.sv]
module arr_edge import arr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  s1_t  data_i,
  output logic ready_o,
  output logic valid_o,
  output s3_t  data_o,
  input  logic ready_i
);

  logic v2_q, v3_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  logic adv2, adv3;

  // edge sums
  always_comb begin
    s2_d.status = data_i.status;
    s2_d.left   = edge_t'(data_i.px) + edge_t'({1'b0, data_i.a0x}) +
                  edge_t'(data_i.o0x) + edge_t'(data_i.ml);
    s2_d.bottom = edge_t'(data_i.py) + edge_t'({1'b0, data_i.a0y}) +
                  edge_t'(data_i.o0y) + edge_t'(data_i.mb);
    s2_d.right  = edge_t'(data_i.px) + edge_t'({1'b0, data_i.a1x}) +
                  edge_t'(data_i.o1x) - edge_t'(data_i.mr);
    s2_d.top    = edge_t'(data_i.py) + edge_t'({1'b0, data_i.a1y}) +
                  edge_t'(data_i.o1y) - edge_t'(data_i.mt);
    s2_d.pl     = data_i.pl;
    s2_d.pb     = data_i.pb;
    s2_d.plr    = data_i.plr;
    s2_d.ptb    = data_i.ptb;
    s2_d.pvx    = data_i.pvx;
    s2_d.pvy    = data_i.pvy;
  end

  // sizes, content box and the late size checks
  always_comb begin
    s3_d.left   = s2_q.left;
    s3_d.bottom = s2_q.bottom;
    s3_d.w      = s2_q.right - s2_q.left;
    s3_d.h      = s2_q.top - s2_q.bottom;
    s3_d.cl     = s2_q.left + edge_t'(s2_q.pl);
    s3_d.cb     = s2_q.bottom + edge_t'(s2_q.pb);
    s3_d.cw     = s2_q.right - s2_q.left - edge_t'(s2_q.plr);
    s3_d.ch     = s2_q.top - s2_q.bottom - edge_t'(s2_q.ptb);
    s3_d.pvx    = s2_q.pvx;
    s3_d.pvy    = s2_q.pvy;
    s3_d.status = s2_q.status;
    if (s2_q.status == ST_OK) begin
      if (s3_d.w[26] || s3_d.h[26]) begin
        s3_d.status = ST_OUTRECT;
      end else if (s3_d.cw[26] || s3_d.ch[26]) begin
        s3_d.status = ST_PADDING;
      end
    end
  end

  assign adv3    = !v3_q || ready_i;
  assign adv2    = !v2_q || adv3;
  assign ready_o = adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv2) begin
        v2_q <= valid_i;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && valid_i) begin
      s2_q <= s2_d;
    end
    if (adv3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = s3_q;

  a_ok_sizes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (s3_q.status == ST_OK) |-> !s3_q.w[26] && !s3_q.h[26] &&
      (s3_q.cw <= s3_q.w) && (s3_q.ch <= s3_q.h))
    else $error("accepted rectangle with bad sizes");

  a_outrect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (s3_q.status == ST_OUTRECT) |-> s3_q.w[26] || s3_q.h[26])
    else $error("output rect status without negative size");

endmodule

[src/arr_pivot.sv]
module arr_pivot import arr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  s3_t  data_i,
  output logic ready_o,
  output logic valid_o,
  output s4_t  data_o,
  input  logic ready_i
);

  logic        v_q;
  s4_t         s_d, s_q;
  logic        adv;
  logic [42:0] prod_x, prod_y;

  // sizes are non-negative whenever the pivot is used
  always_comb begin
    prod_x      = 43'(data_i.w[25:0]) * 43'(data_i.pvx);
    prod_y      = 43'(data_i.h[25:0]) * 43'(data_i.pvy);
    s_d.status  = data_i.status;
    s_d.left    = data_i.left;
    s_d.bottom  = data_i.bottom;
    s_d.w       = data_i.w;
    s_d.h       = data_i.h;
    s_d.cl      = data_i.cl;
    s_d.cb      = data_i.cb;
    s_d.cw      = data_i.cw;
    s_d.ch      = data_i.ch;
    s_d.pox     = prod_x[42:16];
    s_d.poy     = prod_y[42:16];
  end

  assign adv     = !v_q || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      s_q <= s_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = s_q;

endmodule

[src/anchored_rect_resolver_unit.sv]
// Anchored rectangle resolver: one widget per transfer, one result per widget.
// A new widget can be taken every clock cycle while the output side accepts results;
// each result passes through five registered stages (checks and all multiplies,
// edge sums, sizes and content box, pivot multiply, saturation into the output
// register), and a result waits there while the output side holds off. Stages
// without an item let later items close up, so a stalled result does not
// block input until all five stages are full. A non-zero status reports the
// first failing check; all other result fields are then zero.
module anchored_rect_resolver_unit import arr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  arr_in_if.sink     in_i,
  arr_out_if.source  out_o
);

  logic  v1, v3, v4;
  logic  r1, r3, r4;
  s1_t   d1;
  s3_t   d3;
  s4_t   d4;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] rect_x;
    logic [23:0] rect_y;
    logic [22:0] rect_width;
    logic [22:0] rect_height;
    logic [23:0] content_x;
    logic [23:0] content_y;
    logic [22:0] inner_width;
    logic [22:0] inner_height;
    logic [23:0] pivot_x;
    logic [23:0] pivot_y;
  } res_t;

  logic  out_v_q;
  res_t  res_d, res_q;
  logic  adv;
  logic signed [27:0] pvt_x, pvt_y;

  arr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (v1),
    .data_o  (d1),
    .ready_i (r1)
  );

  arr_edge u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .data_i  (d1),
    .ready_o (r1),
    .valid_o (v3),
    .data_o  (d3),
    .ready_i (r3)
  );

  arr_pivot u_pivot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .data_i  (d3),
    .ready_o (r3),
    .valid_o (v4),
    .data_o  (d4),
    .ready_i (r4)
  );

  always_comb begin
    pvt_x = 28'(d4.left) + 28'({1'b0, d4.pox});
    pvt_y = 28'(d4.bottom) + 28'({1'b0, d4.poy});
    res_d = '0;
    res_d.status = d4.status;
    if (d4.status == ST_OK) begin
      res_d.rect_x       = sat_coord(28'(d4.left));
      res_d.rect_y       = sat_coord(28'(d4.bottom));
      res_d.rect_width   = sat_size(28'(d4.w));
      res_d.rect_height  = sat_size(28'(d4.h));
      res_d.content_x    = sat_coord(28'(d4.cl));
      res_d.content_y    = sat_coord(28'(d4.cb));
      res_d.inner_width  = sat_size(28'(d4.cw));
      res_d.inner_height = sat_size(28'(d4.ch));
      res_d.pivot_x      = sat_coord(pvt_x);
      res_d.pivot_y      = sat_coord(pvt_y);
    end
  end

  assign adv = !out_v_q || out_o.ready;
  assign r4  = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v4) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.status       = res_q.status;
  assign out_o.rect_x       = res_q.rect_x;
  assign out_o.rect_y       = res_q.rect_y;
  assign out_o.rect_width   = res_q.rect_width;
  assign out_o.rect_height  = res_q.rect_height;
  assign out_o.content_x    = res_q.content_x;
  assign out_o.content_y    = res_q.content_y;
  assign out_o.inner_width  = res_q.inner_width;
  assign out_o.inner_height = res_q.inner_height;
  assign out_o.pivot_x      = res_q.pivot_x;
  assign out_o.pivot_y      = res_q.pivot_y;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != ST_OK) |->
      (out_o.rect_x == 24'sd0) && (out_o.rect_width == 23'd0) &&
      (out_o.inner_width == 23'd0) && (out_o.pivot_x == 24'sd0))
    else $error("failed item carries a non-zero rectangle");

  a_content_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == ST_OK) |->
      (out_o.inner_width <= out_o.rect_width) &&
      (out_o.inner_height <= out_o.rect_height))
    else $error("content larger than outer rectangle");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input held off while output side is free");

endmodule

[sim/tb_anchored_rect_resolver_unit.sv]
module tb_anchored_rect_resolver_unit;
  import arr_pkg::*;

  // the 18-bit pair fields are held at 40 bits, upper bits always zero
  typedef struct {
    logic [39:0] parent_position;
    logic [39:0] parent_size;
    logic [39:0] anchor_low;
    logic [39:0] anchor_high;
    logic [39:0] pivot_fraction;
    logic [39:0] offset_low;
    logic [39:0] offset_high;
    logic [39:0] margin_horizontal;
    logic [39:0] margin_vertical;
    logic [39:0] padding_horizontal;
    logic [39:0] padding_vertical;
    logic [15:0] scale_factor;
  } widget_t;

  typedef struct {
    status_e     status;
    logic [23:0] rect_x;
    logic [23:0] rect_y;
    logic [22:0] rect_width;
    logic [22:0] rect_height;
    logic [23:0] content_x;
    logic [23:0] content_y;
    logic [22:0] inner_width;
    logic [22:0] inner_height;
    logic [23:0] pivot_x;
    logic [23:0] pivot_y;
  } layout_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  arr_in_if  in_bus ();
  arr_out_if out_bus ();

  anchored_rect_resolver_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  layout_t layout_q[$];
  bit      failed;
  bit      idle_on;
  int      hold_request;
  int      results_seen;
  int      status_seen[8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- fields

  function automatic longint part(input logic [39:0] v, input int lsb, input int w);
    longint r;
    r = longint'((v >> lsb) & ((40'd1 << w) - 40'd1));
    if (r[w-1]) r = r - (longint'(1) << w);
    return r;
  endfunction

  function automatic logic [39:0] pair(input longint lo, input longint hi, input int w);
    logic [39:0] m;
    m = (40'd1 << w) - 40'd1;
    return (40'(lo) & m) | ((40'(hi) & m) << w);
  endfunction

  function automatic logic [39:0] set_half(input logic [39:0] v, input bit upper,
                                           input int w, input longint x);
    return upper ? pair(part(v, 0, w), x, w) : pair(x, part(v, w, w), w);
  endfunction

  // ------------------------------------------------------------ prediction

  function automatic bit frac_ok(input longint v);
    return v >= 0 && v <= longint'(UnitOne);
  endfunction

  // Q4.12 scale, floor of the shift
  function automatic longint dpi_mul(input longint v, input longint dpi);
    return (v * dpi) >>> 12;
  endfunction

  function automatic logic [23:0] clamp_coord(input longint v);
    if (v < longint'(CoordMin)) return 24'h800000;
    if (v > longint'(CoordMax)) return 24'h7FFFFF;
    return v[23:0];
  endfunction

  function automatic logic [22:0] clamp_size(input longint v);
    if (v < 0) return 23'd0;
    if (v > longint'(CoordMax)) return 23'h7FFFFF;
    return v[22:0];
  endfunction

  function automatic layout_t resolve_layout(input widget_t w);
    layout_t r;
    longint px, py, pw, ph, a0x, a0y, a1x, a1y, pvx, pvy;
    longint o0x, o0y, o1x, o1y, ml, mr, mb, mt, pl, pr, pb, pt, dpi;
    longint lft, bot, rgt, top, wd, ht, cl, cb, cw, ch;
    status_e st;
    r = '{status: ST_OK, default: '0};
    px  = part(w.parent_position, 0, 20);    py  = part(w.parent_position, 20, 20);
    pw  = part(w.parent_size, 0, 20);        ph  = part(w.parent_size, 20, 20);
    a0x = part(w.anchor_low, 0, 18);         a0y = part(w.anchor_low, 18, 18);
    a1x = part(w.anchor_high, 0, 18);        a1y = part(w.anchor_high, 18, 18);
    pvx = part(w.pivot_fraction, 0, 18);     pvy = part(w.pivot_fraction, 18, 18);
    o0x = part(w.offset_low, 0, 20);         o0y = part(w.offset_low, 20, 20);
    o1x = part(w.offset_high, 0, 20);        o1y = part(w.offset_high, 20, 20);
    ml  = part(w.margin_horizontal, 0, 20);  mr  = part(w.margin_horizontal, 20, 20);
    mb  = part(w.margin_vertical, 0, 20);    mt  = part(w.margin_vertical, 20, 20);
    pl  = part(w.padding_horizontal, 0, 20); pr  = part(w.padding_horizontal, 20, 20);
    pb  = part(w.padding_vertical, 0, 20);   pt  = part(w.padding_vertical, 20, 20);
    dpi = longint'($signed(w.scale_factor));

    st = ST_OK;
    if (pw < 0 || ph < 0) begin
      st = ST_PARENT;
    end else if (!frac_ok(a0x) || !frac_ok(a0y) || !frac_ok(a1x) || !frac_ok(a1y) ||
                 a0x > a1x || a0y > a1y) begin
      st = ST_ANCHOR;
    end else if (!frac_ok(pvx) || !frac_ok(pvy)) begin
      st = ST_PIVOT;
    end else if (dpi <= 0) begin
      st = ST_DPI;
    end else if (ml < 0 || mr < 0 || mb < 0 || mt < 0) begin
      st = ST_MARGIN;
    end else if (pl < 0 || pr < 0 || pb < 0 || pt < 0) begin
      st = ST_PADDING;
    end

    if (st == ST_OK) begin
      lft = px + ((pw * a0x) >>> 16) + dpi_mul(o0x, dpi) + dpi_mul(ml, dpi);
      bot = py + ((ph * a0y) >>> 16) + dpi_mul(o0y, dpi) + dpi_mul(mb, dpi);
      rgt = px + ((pw * a1x) >>> 16) + dpi_mul(o1x, dpi) - dpi_mul(mr, dpi);
      top = py + ((ph * a1y) >>> 16) + dpi_mul(o1y, dpi) - dpi_mul(mt, dpi);
      wd = rgt - lft;
      ht = top - bot;
      if (wd < 0 || ht < 0) begin
        st = ST_OUTRECT;
      end else begin
        cl = lft + dpi_mul(pl, dpi);
        cb = bot + dpi_mul(pb, dpi);
        cw = wd - dpi_mul(pl + pr, dpi);
        ch = ht - dpi_mul(pt + pb, dpi);
        if (cw < 0 || ch < 0) begin
          st = ST_PADDING;
        end else begin
          r.rect_x       = clamp_coord(lft);
          r.rect_y       = clamp_coord(bot);
          r.rect_width   = clamp_size(wd);
          r.rect_height  = clamp_size(ht);
          r.content_x    = clamp_coord(cl);
          r.content_y    = clamp_coord(cb);
          r.inner_width  = clamp_size(cw);
          r.inner_height = clamp_size(ch);
          r.pivot_x      = clamp_coord(lft + ((wd * pvx) >>> 16));
          r.pivot_y      = clamp_coord(bot + ((ht * pvy) >>> 16));
        end
      end
    end
    r.status = st;
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic longint pick(input longint lo, input longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic longint pick_frac();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return longint'(UnitOne);
    return pick(0, longint'(UnitOne));
  endfunction

  // mostly back to back or short, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic widget_t nominal_widget();
    widget_t w;
    w.parent_position    = pair(160, -80, 20);
    w.parent_size        = pair(3200, 1600, 20);
    w.anchor_low         = pair(0, 0, 18);
    w.anchor_high        = pair(65536, 65536, 18);
    w.pivot_fraction     = pair(32768, 32768, 18);
    w.offset_low         = pair(0, 0, 20);
    w.offset_high        = pair(0, 0, 20);
    w.margin_horizontal  = pair(16, 16, 20);
    w.margin_vertical    = pair(16, 16, 20);
    w.padding_horizontal = pair(8, 8, 20);
    w.padding_vertical   = pair(8, 8, 20);
    w.scale_factor       = 16'd4096;
    return w;
  endfunction

  // passes every input check; outer and content size may still go negative
  function automatic widget_t random_layout();
    widget_t w;
    bit     wide;
    longint lim, szl, ofl, mgl, a0x, a0y;
    wide = ($urandom_range(0, 9) == 0);
    lim = wide ? 524287 : 20000;
    szl = wide ? 524287 : 30000;
    ofl = wide ? 524287 : 1500;
    mgl = wide ? 524287 : 600;
    a0x = pick_frac();
    a0y = pick_frac();
    w.parent_position    = pair(pick(-lim - 1, lim), pick(-lim - 1, lim), 20);
    w.parent_size        = pair(pick(0, szl), pick(0, szl), 20);
    w.anchor_low         = pair(a0x, a0y, 18);
    w.anchor_high        = pair(pick(a0x, 65536), pick(a0y, 65536), 18);
    w.pivot_fraction     = pair(pick_frac(), pick_frac(), 18);
    w.offset_low         = pair(pick(-ofl - 1, ofl), pick(-ofl - 1, ofl), 20);
    w.offset_high        = pair(pick(-ofl - 1, ofl), pick(-ofl - 1, ofl), 20);
    w.margin_horizontal  = pair(pick(0, mgl), pick(0, mgl), 20);
    w.margin_vertical    = pair(pick(0, mgl), pick(0, mgl), 20);
    w.padding_horizontal = pair(pick(0, mgl), pick(0, mgl), 20);
    w.padding_vertical   = pair(pick(0, mgl), pick(0, mgl), 20);
    w.scale_factor       = 16'(wide ? pick(1, 32767) : pick(2048, 8192));
    return w;
  endfunction

  // spoil one check of an otherwise sound widget
  function automatic widget_t break_layout(input widget_t w);
    bit     upper, other;
    longint a, bad;
    upper = 1'($urandom_range(0, 1));
    other = 1'($urandom_range(0, 1));
    bad = other ? pick(65537, 131071) : pick(-131072, -1);
    case ($urandom_range(0, 7))
      0: begin
        w.parent_size = set_half(w.parent_size, upper, 20, pick(-524288, -1));
      end
      1: begin
        if ($urandom_range(0, 1)) w.anchor_low = set_half(w.anchor_low, upper, 18, bad);
        else w.anchor_high = set_half(w.anchor_high, upper, 18, bad);
      end
      2: begin
        // minimum anchor above maximum on one axis
        a = pick(0, 65535);
        w.anchor_high = set_half(w.anchor_high, upper, 18, a);
        w.anchor_low  = set_half(w.anchor_low, upper, 18, pick(a + 1, 65536));
      end
      3: begin
        w.pivot_fraction = set_half(w.pivot_fraction, upper, 18, bad);
      end
      4: begin
        w.scale_factor = 16'(pick(-32768, 0));
      end
      5: begin
        if (other) w.margin_horizontal = set_half(w.margin_horizontal, upper, 20,
                                                  pick(-524288, -1));
        else w.margin_vertical = set_half(w.margin_vertical, upper, 20, pick(-524288, -1));
      end
      6: begin
        if (other) w.padding_horizontal = set_half(w.padding_horizontal, upper, 20,
                                                   pick(-524288, -1));
        else w.padding_vertical = set_half(w.padding_vertical, upper, 20, pick(-524288, -1));
      end
      default: begin
        w.padding_horizontal = pair(pick(20000, 524287), pick(20000, 524287), 20);
      end
    endcase
    return w;
  endfunction

  function automatic widget_t random_bits();
    widget_t w;
    w.parent_position    = 40'({$urandom, $urandom});
    w.parent_size        = 40'({$urandom, $urandom});
    w.anchor_low         = {4'd0, 36'({$urandom, $urandom})};
    w.anchor_high        = {4'd0, 36'({$urandom, $urandom})};
    w.pivot_fraction     = {4'd0, 36'({$urandom, $urandom})};
    w.offset_low         = 40'({$urandom, $urandom});
    w.offset_high        = 40'({$urandom, $urandom});
    w.margin_horizontal  = 40'({$urandom, $urandom});
    w.margin_vertical    = 40'({$urandom, $urandom});
    w.padding_horizontal = 40'({$urandom, $urandom});
    w.padding_vertical   = 40'({$urandom, $urandom});
    w.scale_factor       = 16'($urandom);
    return w;
  endfunction

  // valid is only lowered when a gap follows, so back-to-back transfers keep it high
  task automatic send_widget(input widget_t w);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid              <= 1'b1;
    in_bus.parent_position    <= w.parent_position;
    in_bus.parent_size        <= w.parent_size;
    in_bus.anchor_low         <= w.anchor_low[35:0];
    in_bus.anchor_high        <= w.anchor_high[35:0];
    in_bus.pivot_fraction     <= w.pivot_fraction[35:0];
    in_bus.offset_low         <= w.offset_low;
    in_bus.offset_high        <= w.offset_high;
    in_bus.margin_horizontal  <= w.margin_horizontal;
    in_bus.margin_vertical    <= w.margin_vertical;
    in_bus.padding_horizontal <= w.padding_horizontal;
    in_bus.padding_vertical   <= w.padding_vertical;
    in_bus.scale_factor       <= w.scale_factor;
    do @(posedge clk_i); while (!in_bus.ready);
    layout_q.push_back(resolve_layout(w));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_status_checks();
    widget_t w;
    send_widget(nominal_widget());
    w = nominal_widget(); w.parent_size = pair(-1, 1600, 20); send_widget(w);
    w = nominal_widget(); w.parent_size = pair(3200, -524288, 20); send_widget(w);
    w = nominal_widget(); w.anchor_low = pair(-1, 0, 18); send_widget(w);
    w = nominal_widget(); w.anchor_high = pair(65537, 65536, 18); send_widget(w);
    w = nominal_widget();
    w.anchor_low = pair(40000, 0, 18); w.anchor_high = pair(30000, 65536, 18);
    send_widget(w);
    w = nominal_widget();
    w.anchor_low = pair(0, 65536, 18); w.anchor_high = pair(65536, 65535, 18);
    send_widget(w);
    // equal min and max anchors are allowed
    w = nominal_widget();
    w.anchor_low = pair(65536, 0, 18); w.anchor_high = pair(65536, 0, 18);
    send_widget(w);
    w = nominal_widget(); w.pivot_fraction = pair(65537, 0, 18); send_widget(w);
    w = nominal_widget(); w.pivot_fraction = pair(0, -131072, 18); send_widget(w);
    w = nominal_widget(); w.scale_factor = 16'd0; send_widget(w);
    w = nominal_widget(); w.scale_factor = 16'h8000; send_widget(w);
    w = nominal_widget(); w.margin_horizontal = pair(0, -1, 20); send_widget(w);
    w = nominal_widget(); w.margin_vertical = pair(-16, 0, 20); send_widget(w);
    w = nominal_widget(); w.padding_horizontal = pair(-1, 0, 20); send_widget(w);
    w = nominal_widget(); w.padding_vertical = pair(0, -524288, 20); send_widget(w);
    w = nominal_widget(); w.offset_high = pair(-4000, 0, 20); send_widget(w);
    w = nominal_widget(); w.margin_vertical = pair(1000, 1000, 20); send_widget(w);
    // outer box fine, padding leaves a negative content box
    w = nominal_widget(); w.padding_horizontal = pair(2000, 2000, 20); send_widget(w);
  endtask

  task automatic test_field_extremes();
    widget_t w;
    // widest possible box: sizes saturate
    w = nominal_widget();
    w.parent_position    = pair(-524288, -524288, 20);
    w.parent_size        = pair(524287, 524287, 20);
    w.offset_low         = pair(-524288, -524288, 20);
    w.offset_high        = pair(524287, 524287, 20);
    w.margin_horizontal  = pair(0, 0, 20);
    w.margin_vertical    = pair(0, 0, 20);
    w.padding_horizontal = pair(0, 0, 20);
    w.padding_vertical   = pair(0, 0, 20);
    w.pivot_fraction     = pair(65536, 0, 18);
    w.scale_factor       = 16'sd32767;
    send_widget(w);
    // zero parent, smallest scale
    w = nominal_widget();
    w.parent_size = pair(0, 0, 20); w.scale_factor = 16'd1;
    send_widget(w);
    // odd sizes and negative offsets exercise the floor of each shift
    w = nominal_widget();
    w.parent_size    = pair(3201, 1599, 20);
    w.anchor_low     = pair(1, 3, 18);
    w.anchor_high    = pair(65535, 65533, 18);
    w.pivot_fraction = pair(1, 65535, 18);
    w.offset_low     = pair(-3, -7, 20);
    w.offset_high    = pair(-1, -5, 20);
    w.scale_factor   = 16'd4097;
    send_widget(w);
    w = nominal_widget();
    w.parent_position = pair(-1, 524287, 20);
    w.anchor_low      = pair(65536, 65536, 18);
    w.pivot_fraction  = pair(0, 0, 18);
    w.margin_horizontal = pair(0, 0, 20);
    w.margin_vertical   = pair(0, 0, 20);
    w.padding_horizontal = pair(0, 0, 20);
    w.padding_vertical   = pair(0, 0, 20);
    send_widget(w);
  endtask

  task automatic test_random_layouts(input int count);
    widget_t w;
    repeat (count) begin
      w = random_layout();
      if ($urandom_range(0, 99) < 15) w = break_layout(w);
      send_widget(w);
    end
  endtask

  task automatic test_random_noise(input int count);
    repeat (count) send_widget(random_bits());
  endtask

  // output held off for a long stretch while widgets keep coming back to back
  task automatic test_output_backpressure(input int count);
    idle_on = 1'b0;
    hold_request = 80;
    repeat (count) send_widget(random_layout());
    idle_on = 1'b1;
  endtask

  // ------------------------------------------------------------- receiver

  initial begin
    int n;
    out_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    layout_t e;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (layout_q.size() == 0) begin
        $error("result transfer with nothing expected, status %0d", out_bus.status);
        failed = 1'b1;
      end else begin
        e = layout_q.pop_front();
        results_seen++;
        status_seen[out_bus.status]++;
        check_field("status", longint'(e.status), longint'(out_bus.status));
        check_field("rect_x", longint'($signed(e.rect_x)), longint'(out_bus.rect_x));
        check_field("rect_y", longint'($signed(e.rect_y)), longint'(out_bus.rect_y));
        check_field("rect_width", longint'(e.rect_width), longint'(out_bus.rect_width));
        check_field("rect_height", longint'(e.rect_height), longint'(out_bus.rect_height));
        check_field("content_x", longint'($signed(e.content_x)),
                    longint'(out_bus.content_x));
        check_field("content_y", longint'($signed(e.content_y)),
                    longint'(out_bus.content_y));
        check_field("inner_width", longint'(e.inner_width),
                    longint'(out_bus.inner_width));
        check_field("inner_height", longint'(e.inner_height),
                    longint'(out_bus.inner_height));
        check_field("pivot_x", longint'($signed(e.pivot_x)), longint'(out_bus.pivot_x));
        check_field("pivot_y", longint'($signed(e.pivot_y)), longint'(out_bus.pivot_y));
      end
    end
  end

  // ----------------------------------------------------------------- main

  initial begin
    failed       = 1'b0;
    idle_on      = 1'b1;
    hold_request = 0;
    results_seen = 0;
    rst_ni       = 1'b0;
    in_bus.valid              = 1'b0;
    in_bus.parent_position    = '0;
    in_bus.parent_size        = '0;
    in_bus.anchor_low         = '0;
    in_bus.anchor_high        = '0;
    in_bus.pivot_fraction     = '0;
    in_bus.offset_low         = '0;
    in_bus.offset_high        = '0;
    in_bus.margin_horizontal  = '0;
    in_bus.margin_vertical    = '0;
    in_bus.padding_horizontal = '0;
    in_bus.padding_vertical   = '0;
    in_bus.scale_factor       = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_status_checks();
    test_field_extremes();
    test_random_layouts(1100);
    test_output_backpressure(200);
    test_random_noise(300);
    test_random_layouts(30);

    in_bus.valid <= 1'b0;
    while (layout_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Resolved %0d widgets: directed checks, saturating extremes, random",
             results_seen);
    $display("layouts, raw noise and a long output stall (ok %0d, parent %0d, anchor %0d,",
             status_seen[ST_OK], status_seen[ST_PARENT], status_seen[ST_ANCHOR]);
    $display("  pivot %0d, dpi %0d, margin %0d, padding %0d, outer rect %0d)",
             status_seen[ST_PIVOT], status_seen[ST_DPI], status_seen[ST_MARGIN],
             status_seen[ST_PADDING], status_seen[ST_OUTRECT]);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
